[hdl/spq_pkg.sv]
// Shared types, codes and constants of the three-level stable priority queue.
package spq_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 16;

    localparam int unsigned CUST_W   = 16;
    localparam int unsigned LEVEL_W  = 2;
    localparam int unsigned TICKET_W = 14;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned LIMIT_W  = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 14;

    localparam logic [TICKET_W-1:0] TICKET_LAST     = TICKET_W'(9999);
    localparam logic [YEAR_W-1:0]   YEAR_RESET      = YEAR_W'(2013);
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET     = LIMIT_W'(11);

    // Input word layout
    localparam int unsigned IN_CUST_LSB  = 0;
    localparam int unsigned IN_WARR_BIT  = 16;
    localparam int unsigned IN_YEAR_LSB  = 17;
    localparam int unsigned IN_TDATA_W   = 32;

    // Output word layout; remaining sits on top, its width follows the depth
    localparam int unsigned OUT_TICKET_LSB = 0;
    localparam int unsigned OUT_CUST_LSB   = 14;
    localparam int unsigned OUT_LEVEL_LSB  = 30;
    localparam int unsigned OUT_REM_LSB    = 32;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SERVE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_INSERTED      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SERVED        = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED_EMPTY = 2'd3;

    localparam logic [LEVEL_W-1:0] LEVEL_NONE   = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_URGENT = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_RECENT = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_OTHER  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_YEAR_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT    = 2'd1;

    typedef struct packed {
        logic [CUST_W-1:0]   customer;
        logic [LEVEL_W-1:0]  level;
        logic [TICKET_W-1:0] ticket;
    } t_spq_entry;

    // Broadcast from the control to every cell
    typedef struct packed {
        logic       ins;
        logic       srv;
        t_spq_entry new_e;
    } t_spq_ctrl;

endpackage

[hdl/spq_cell.sv]
// One cell of the sorted chain: holds one entry, keeps, takes the new word or shifts.
module spq_cell
    import spq_pkg::*;
#(
    parameter int unsigned CELL_IDX = 0,
    parameter int unsigned CNT_W    = 5
) (
    input  logic             i_clk,
    input  t_spq_ctrl        i_ctrl,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_prev_keep,
    input  t_spq_entry       i_prev_e,
    input  t_spq_entry       i_next_e,
    output logic             o_keep,
    output t_spq_entry       o_e
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(CELL_IDX);

    t_spq_entry r_e;
    t_spq_entry n_e;
    logic       occupied;

    // Occupied cells form a prefix; an entry stays put when it ranks at or above the new one
    assign occupied = IDX < i_count;
    assign o_keep   = occupied && (r_e.level <= i_ctrl.new_e.level);
    assign o_e      = r_e;

    always_comb begin
        n_e = r_e;
        if (i_ctrl.ins) begin
            if (!o_keep) begin
                n_e = i_prev_keep ? i_ctrl.new_e : i_prev_e;
            end
        end else if (i_ctrl.srv) begin
            n_e = i_next_e;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;
    end

endmodule

[hdl/three_level_stable_priority_queue_core.sv]
// Top level of the three-level stable priority queue: control, chain of cells, output stage.
//
// Usage
//   Requests arrive on the slave stream (s_*). s_tuser carries the command:
//   insert a repair order or serve the best one. Results leave on the master
//   stream (m_*), one word per request; m_tuser carries the status.
//   Two registers are written through the plain write port (i_cfg_*): the
//   model-year threshold and the entry limit. Write them only while idle.
// Throughput
//   One request per cycle while the output is not stalled. A result appears
//   in the output register in the cycle after its request is taken. The
//   queue is a row of QUEUE_DEPTH cells kept sorted by level and arrival;
//   every cell decides locally whether to hold, load the new word or take its
//   neighbour's word, so insert and serve never walk the row, whatever the fill.
// Reset
//   i_rst_n is synchronous, active low. It empties the queue, zeroes the
//   ticket count and loads the register defaults (2013 and 11). No clearing
//   pass follows; the block takes requests as soon as reset is released.
// Stall
//   The output register holds its word while m_tready is low; s_tready then
//   drops, and no request is taken until the held word leaves.
module three_level_stable_priority_queue_core
    import spq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1),
    localparam int unsigned OUT_W      = OUT_REM_LSB + CNT_W,
    localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // customer_id [15:0], in_warranty [16], model_year [30:17], zero [31]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // cmd [0]
    input  logic                   s_tuser,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // ticket [13:0], served_customer [29:14], priority_level [31:30],
    // remaining [32+CNT_W-1:32], zero above
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [STATUS_W-1:0]    m_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(QUEUE_DEPTH);

    // Configuration registers
    logic [YEAR_W-1:0]  r_year_thr;
    logic [LIMIT_W-1:0] r_limit;

    // Queue control state
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [TICKET_W-1:0] r_ticket;
    logic [TICKET_W-1:0] n_ticket;

    // Output stage
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    t_spq_entry          r_res;
    logic [CNT_W-1:0]    r_rem;
    logic [STATUS_W-1:0] n_status;
    t_spq_entry          n_res;

    logic                accept;
    logic                full;
    logic                empty;
    logic [YEAR_W-1:0]   in_year;
    logic [LEVEL_W-1:0]  new_level;
    t_spq_ctrl           ctrl;

    t_spq_entry          cell_e    [QUEUE_DEPTH];
    logic                cell_keep [QUEUE_DEPTH];

    assign s_tready = !r_out_valid || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign in_year = s_tdata[IN_YEAR_LSB +: YEAR_W];
    assign full    = (CMP_W'(r_count) >= CMP_W'(r_limit)) || (CMP_W'(r_count) >= DEPTH_C);
    assign empty   = (r_count == '0);

    // Warranty wins; then recent model years; everything else last
    always_comb begin
        if (s_tdata[IN_WARR_BIT]) begin
            new_level = LEVEL_URGENT;
        end else if (in_year > r_year_thr) begin
            new_level = LEVEL_RECENT;
        end else begin
            new_level = LEVEL_OTHER;
        end
    end

    assign ctrl.ins            = accept && (s_tuser == CMD_INSERT) && !full;
    assign ctrl.srv            = accept && (s_tuser == CMD_SERVE) && !empty;
    assign ctrl.new_e.customer = s_tdata[IN_CUST_LSB +: CUST_W];
    assign ctrl.new_e.level    = new_level;
    assign ctrl.new_e.ticket   = r_ticket;

    // Build the result word and the next count and ticket
    always_comb begin
        n_count  = r_count;
        n_ticket = r_ticket;
        n_status = STATUS_REFUSED_EMPTY;
        n_res    = '0;
        if (s_tuser == CMD_INSERT) begin
            if (full) begin
                n_status = STATUS_REFUSED_FULL;
            end else begin
                n_status     = STATUS_INSERTED;
                n_res.level  = new_level;
                n_res.ticket = r_ticket;
                n_count      = r_count + CNT_W'(1);
                n_ticket     = (r_ticket == TICKET_LAST) ? '0 : r_ticket + TICKET_W'(1);
            end
        end else if (!empty) begin
            // Head cell holds the lowest level, earliest arrival
            n_status = STATUS_SERVED;
            n_res    = cell_e[0];
            n_count  = r_count - CNT_W'(1);
        end
    end

    // Chain of cells; the head has no upstream neighbour and always sees "keep"
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic       prev_keep;
        t_spq_entry prev_e;
        t_spq_entry next_e;

        if (g == 0) begin : g_head
            assign prev_keep = 1'b1;
            assign prev_e    = cell_e[g];
        end else begin : g_body
            assign prev_keep = cell_keep[g-1];
            assign prev_e    = cell_e[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign next_e = cell_e[g];
        end else begin : g_mid
            assign next_e = cell_e[g+1];
        end

        spq_cell #(
            .CELL_IDX (g),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_count     (r_count),
            .i_prev_keep (prev_keep),
            .i_prev_e    (prev_e),
            .i_next_e    (next_e),
            .o_keep      (cell_keep[g]),
            .o_e         (cell_e[g])
        );
    end

    // Configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year_thr <= YEAR_RESET;
            r_limit    <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_YEAR_THRESHOLD: r_year_thr <= i_cfg_wdata[YEAR_W-1:0];
                REG_ENTRY_LIMIT:    r_limit    <= i_cfg_wdata[LIMIT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Advance count and ticket on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ticket <= '0;
        end else if (accept) begin
            r_count  <= n_count;
            r_ticket <= n_ticket;
        end
    end

    // Output register: load on accept, clear valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_res    <= n_res;
            r_rem    <= n_count;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_status;

    always_comb begin
        m_tdata = '0;
        m_tdata[OUT_TICKET_LSB +: TICKET_W] = r_res.ticket;
        m_tdata[OUT_CUST_LSB +: CUST_W]     = r_res.customer;
        m_tdata[OUT_LEVEL_LSB +: LEVEL_W]   = r_res.level;
        m_tdata[OUT_REM_LSB +: CNT_W]       = r_rem;
    end

endmodule

[hdl/spq_checker.sv]
// Port-level checks of the priority queue core, bound to the top level.
module spq_checker
    import spq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1),
    localparam int unsigned OUT_W      = OUT_REM_LSB + CNT_W,
    localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]    m_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready
);

    // Output stage empty after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    // A held result keeps its word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Every accepted request yields a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request gave no result");

    // Refused-empty leaves nothing behind
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == STATUS_REFUSED_EMPTY) |->
            (m_tdata[OUT_REM_LSB +: CNT_W] == '0))
        else $error("refused empty with entries left");

    // Inserted or served words carry a real level
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && ((m_tuser == STATUS_INSERTED) || (m_tuser == STATUS_SERVED)) |->
            (m_tdata[OUT_LEVEL_LSB +: LEVEL_W] != LEVEL_NONE))
        else $error("granted word without level");

endmodule

bind three_level_stable_priority_queue_core spq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (.*);
